// ===== hdl/sok_pkg.sv =====
// Shared types and constants for the stochastic oscillator %K block.
// No dependencies; used by every module of the block except sok_ram.
package sok_pkg;

    localparam int PRICE_W   = 32;
    localparam int K_W       = 15;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int DIV_CNT_W = 4;

    localparam logic [K_W-1:0]       K_FULL_SCALE   = 15'd25600;
    localparam logic [CFG_W-1:0]     LOOKBACK_RESET = 7'd14;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST       = 4'd14;

    // register word index (paddr[2])
    localparam logic REG_LOOKBACK = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic calc;
        logic mul;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic needs_div;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sok_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sok_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sok_ctrl.sv =====
// Sequencer for the %K block: accept, window scan, clamp check, divide, output.
// Depends on sok_pkg.
module sok_ctrl #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  sok_pkg::status_t                 status,
    input  logic [$clog2(MAX_PERIOD+1)-1:0]  period,
    output sok_pkg::cmd_t                    cmd
);

    localparam int PW = $clog2(MAX_PERIOD + 1);

    sok_pkg::state_t                state_reg, state_next;
    logic [PW-1:0]                  scan_cnt_reg, scan_cnt_next;
    logic [sok_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sok_pkg::ST_IDLE;
            scan_cnt_reg <= '0;
            div_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            sok_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load      = 1'b1;
                    scan_cnt_next = '0;
                    state_next    = sok_pkg::ST_SCAN;
                end
            end
            sok_pkg::ST_SCAN: begin
                if (!status.full) begin
                    state_next = sok_pkg::ST_DONE;
                end else begin
                    cmd.rd_en     = 1'b1;
                    scan_cnt_next = scan_cnt_reg + PW'(1);
                    if (scan_cnt_reg == period - PW'(1)) begin
                        state_next = sok_pkg::ST_DRAIN;
                    end
                end
            end
            sok_pkg::ST_DRAIN: begin
                state_next = sok_pkg::ST_CALC;
            end
            sok_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = status.needs_div ? sok_pkg::ST_MUL : sok_pkg::ST_DONE;
            end
            sok_pkg::ST_MUL: begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = sok_pkg::ST_DIV;
            end
            sok_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + sok_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == sok_pkg::DIV_LAST) begin
                    state_next = sok_pkg::ST_DONE;
                end
            end
            sok_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sok_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sok_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sok_dp.sv =====
// Datapath for the %K block: high/low rings, min/max scan, clamp, multiply,
// restoring divider and output register. Depends on sok_pkg and sok_ram.
module sok_dp #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sok_pkg::cmd_t                       cmd,
    input  logic [sok_pkg::CFG_W-1:0]           lookback,
    input  logic [sok_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [sok_pkg::S_TUSER_W-1:0]       s_tuser,
    input  logic                                m_tready,
    output sok_pkg::status_t                    status,
    output logic [$clog2(MAX_PERIOD+1)-1:0]     period,
    output logic                                m_tvalid,
    output logic [sok_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [sok_pkg::M_TUSER_W-1:0]       m_tuser
);

    localparam int AW  = $clog2(MAX_PERIOD);
    localparam int PW  = $clog2(MAX_PERIOD + 1);
    localparam int CW  = (PW > sok_pkg::CFG_W) ? PW : sok_pkg::CFG_W;
    localparam int PRW = sok_pkg::PRICE_W;
    localparam int KW  = sok_pkg::K_W;
    localparam int MW  = PRW + KW;

    logic [PRW-1:0] in_high, in_low, in_close;
    logic           in_first;

    assign in_high  = s_tdata[PRW-1:0];
    assign in_low   = s_tdata[2*PRW-1:PRW];
    assign in_close = s_tdata[3*PRW-1:2*PRW];
    assign in_first = s_tuser[0];

    // effective window length
    logic [CW-1:0] lb_ext;
    assign lb_ext = CW'(lookback);
    always_comb begin
        if (lb_ext == '0) begin
            period = PW'(1);
        end else if (lb_ext > CW'(MAX_PERIOD)) begin
            period = PW'(MAX_PERIOD);
        end else begin
            period = PW'(lb_ext);
        end
    end

    logic [AW-1:0]  write_slot_reg, write_slot_next;
    logic [PW-1:0]  bars_seen_reg, bars_seen_next;
    logic [AW-1:0]  newest;
    logic [PW-1:0]  bars_base;
    logic           full_reg;
    logic [AW-1:0]  rd_addr_reg;
    logic           rd_vld_reg;
    logic [PRW-1:0] close_reg, hmax_reg, lmin_reg;
    logic [PRW-1:0] num_reg, den_reg, rem_reg;
    logic [KW-1:0]  quo_reg, res_k_reg;
    logic           res_valid_reg, res_flat_reg, use_div_reg;
    logic           out_valid_reg, out_rv_reg, out_flat_reg;
    logic [KW-1:0]  out_k_reg;
    logic [PRW-1:0] high_rd, low_rd;

    assign newest          = in_first ? '0 : write_slot_reg;
    assign write_slot_next = (newest == AW'(MAX_PERIOD - 1)) ? '0 : newest + AW'(1);
    assign bars_base       = in_first ? '0 : bars_seen_reg;
    assign bars_seen_next  = (bars_base < PW'(MAX_PERIOD)) ? bars_base + PW'(1) : bars_base;

    sok_ram #(.WIDTH(PRW), .DEPTH(MAX_PERIOD)) u_high_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (newest),
        .wdata (in_high),
        .re    (cmd.rd_en),
        .raddr (rd_addr_reg),
        .rdata (high_rd)
    );

    sok_ram #(.WIDTH(PRW), .DEPTH(MAX_PERIOD)) u_low_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (newest),
        .wdata (in_low),
        .re    (cmd.rd_en),
        .raddr (rd_addr_reg),
        .rdata (low_rd)
    );

    logic flat, clamp_lo, clamp_hi;
    assign flat     = hmax_reg <= lmin_reg;
    assign clamp_lo = close_reg <= lmin_reg;
    assign clamp_hi = close_reg >= hmax_reg;

    logic [MW-1:0]  prod;
    logic [PRW:0]   trial;
    logic           trial_ge;
    logic [PRW:0]   trial_sub;

    assign prod      = MW'(num_reg) * MW'(sok_pkg::K_FULL_SCALE);
    assign trial     = {rem_reg, quo_reg[KW-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            bars_seen_reg  <= '0;
            full_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.load) begin
                write_slot_reg <= write_slot_next;
                bars_seen_reg  <= bars_seen_next;
                full_reg       <= bars_seen_next >= period;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            close_reg     <= in_close;
            rd_addr_reg   <= newest;
            hmax_reg      <= '0;
            lmin_reg      <= '1;
            res_valid_reg <= 1'b0;
            res_flat_reg  <= 1'b0;
            res_k_reg     <= '0;
            use_div_reg   <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                rd_addr_reg <= (rd_addr_reg == '0) ? AW'(MAX_PERIOD - 1)
                                                   : rd_addr_reg - AW'(1);
            end
            if (rd_vld_reg) begin
                if (high_rd > hmax_reg) begin
                    hmax_reg <= high_rd;
                end
                if (low_rd < lmin_reg) begin
                    lmin_reg <= low_rd;
                end
            end
            if (cmd.calc) begin
                res_valid_reg <= 1'b1;
                res_flat_reg  <= flat;
                res_k_reg     <= (flat || clamp_lo) ? '0 : sok_pkg::K_FULL_SCALE;
                use_div_reg   <= !flat && !clamp_lo && !clamp_hi;
                num_reg       <= close_reg - lmin_reg;
                den_reg       <= hmax_reg - lmin_reg;
            end
        end
        if (cmd.mul) begin
            rem_reg <= prod[MW-1:KW];
            quo_reg <= prod[KW-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[PRW-1:0] : trial[PRW-1:0];
            quo_reg <= {quo_reg[KW-2:0], trial_ge};
        end
        if (cmd.out_load) begin
            out_k_reg    <= use_div_reg ? quo_reg : res_k_reg;
            out_rv_reg   <= res_valid_reg;
            out_flat_reg <= res_flat_reg;
        end
    end

    assign status.full      = full_reg;
    assign status.needs_div = !flat && !clamp_lo && !clamp_hi;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sok_pkg::M_TDATA_W'(out_k_reg);
    assign m_tuser  = {out_flat_reg, out_rv_reg};

endmodule

// ===== hdl/stochastic_oscillator_k.sv =====
// Fast stochastic %K: one bar in, one result out; a new bar is accepted only after the
// last result is loaded. A filling window skips the scan, a flat or clamped one skips
// the 15-step restoring divider. The window scan reads one high/low ring entry per
// cycle. Results wait for a free output register and are held there until taken.
// Synchronous active-low reset clears control, the slot pointer, the bar count and
// sets lookback_period to 14; the rings are not cleared.
module stochastic_oscillator_k #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sok_pkg::APB_AW-1:0]        paddr,
    input  logic [sok_pkg::APB_DW-1:0]        pwdata,
    output logic [sok_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // bar input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sok_pkg::S_TDATA_W-1:0]     s_tdata,  // high_price, low_price, close_price
    input  logic [sok_pkg::S_TUSER_W-1:0]     s_tuser,  // first_sample
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sok_pkg::M_TDATA_W-1:0]     m_tdata,  // percent_k, pad
    output logic [sok_pkg::M_TUSER_W-1:0]     m_tuser   // result_valid, flat_range
);

    localparam int PW = $clog2(MAX_PERIOD + 1);

    logic [sok_pkg::CFG_W-1:0] lookback_reg;
    sok_pkg::cmd_t             cmd;
    sok_pkg::status_t          status;
    logic [PW-1:0]             period;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookback_reg <= sok_pkg::LOOKBACK_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == sok_pkg::REG_LOOKBACK) begin
            lookback_reg <= pwdata[sok_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sok_pkg::REG_LOOKBACK)
                  ? sok_pkg::APB_DW'(lookback_reg) : '0;

    sok_ctrl #(.MAX_PERIOD(MAX_PERIOD)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .period   (period),
        .cmd      (cmd)
    );

    sok_dp #(.MAX_PERIOD(MAX_PERIOD)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .lookback (lookback_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .period   (period),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/sok_chk.sv =====
// Port-level checker for stochastic_oscillator_k, bound to the top level.
// Depends on sok_pkg.
module sok_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sok_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sok_pkg::M_TUSER_W-1:0] m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= sok_pkg::M_TDATA_W'(sok_pkg::K_FULL_SCALE))
        else $error("percent_k out of range");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata == '0)
        else $error("flat window result not zero or not valid");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("unfilled window result not zero");

endmodule

bind stochastic_oscillator_k sok_chk u_sok_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_stochastic_oscillator_k.sv =====
// Self-checking testbench for stochastic_oscillator_k: drives price bars on the input
// stream, programs lookback_period over APB and checks every %K beat against a local model.
// Depends on sok_pkg and the stochastic_oscillator_k RTL.
module tb_stochastic_oscillator_k;

    localparam int WIN_DEPTH       = 64;
    localparam int NUM_PHASES      = 18;
    localparam int PRESSURE_PHASE  = 14;
    localparam int PRESSURE_CYCLES = 300;
    localparam int TAIL_CYCLES     = 100;
    localparam int MAX_PRINTED     = 40;

    localparam logic [sok_pkg::APB_AW-1:0] LOOKBACK_ADDR = {sok_pkg::REG_LOOKBACK, 2'b00};
    localparam logic [sok_pkg::APB_AW-1:0] SPARE_ADDR    = {~sok_pkg::REG_LOOKBACK, 2'b00};

    typedef struct {
        logic [sok_pkg::PRICE_W-1:0] high;
        logic [sok_pkg::PRICE_W-1:0] low;
        logic [sok_pkg::PRICE_W-1:0] close;
        logic                        first;
    } bar_t;

    typedef struct {
        logic [sok_pkg::K_W-1:0] percent_k;
        logic                    valid;
        logic                    flat;
    } k_result_t;

    typedef enum {SER_WALK, SER_FLAT, SER_EDGE, SER_NOISE} series_kind_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [sok_pkg::APB_AW-1:0]    paddr    = '0;
    logic [sok_pkg::APB_DW-1:0]    pwdata   = '0;
    logic [sok_pkg::APB_DW-1:0]    prdata;
    logic                          pready;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sok_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [sok_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sok_pkg::M_TDATA_W-1:0] m_tdata;
    logic [sok_pkg::M_TUSER_W-1:0] m_tuser;

    // window model
    logic [sok_pkg::PRICE_W-1:0] high_win [WIN_DEPTH];
    logic [sok_pkg::PRICE_W-1:0] low_win  [WIN_DEPTH];
    int unsigned                 next_slot  = 0;
    int unsigned                 bars_held  = 0;
    logic [sok_pkg::CFG_W-1:0]   period_reg = sok_pkg::LOOKBACK_RESET;

    bar_t      bar_queue [$];
    k_result_t k_expected [$];

    bit          in_beat     = 1'b0;
    bit          tx_idle_on  = 1'b0;
    bit          rx_idle_on  = 1'b0;
    bit          rx_hold     = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned err_count   = 0;
    int unsigned bars_in     = 0;
    int unsigned results_out = 0;
    int unsigned full_cnt    = 0;
    int unsigned flat_cnt    = 0;
    int unsigned top_cnt     = 0;
    int unsigned zero_cnt    = 0;

    stochastic_oscillator_k #(
        .MAX_PERIOD(WIN_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned window_len(logic [sok_pkg::CFG_W-1:0] p);
        if (p == 0) return 1;
        if (p > WIN_DEPTH) return WIN_DEPTH;
        return p;
    endfunction

    function automatic k_result_t predict_k(bar_t b);
        int unsigned                 span, idx, i;
        logic [sok_pkg::PRICE_W-1:0] hmax, lmin;
        logic [63:0]                 quot;
        k_result_t                   r;
        span = window_len(period_reg);
        if (b.first) begin
            bars_held = 0;
            next_slot = 0;
        end
        idx = next_slot;
        high_win[idx] = b.high;
        low_win[idx]  = b.low;
        next_slot = (idx + 1) % WIN_DEPTH;
        if (bars_held < WIN_DEPTH) bars_held++;
        r = '{percent_k: '0, valid: 1'b0, flat: 1'b0};
        if (bars_held < span) return r;
        hmax = b.high;
        lmin = b.low;
        for (i = 1; i < span; i++) begin
            idx = (idx == 0) ? WIN_DEPTH - 1 : idx - 1;
            if (high_win[idx] > hmax) hmax = high_win[idx];
            if (low_win[idx] < lmin) lmin = low_win[idx];
        end
        r.valid = 1'b1;
        if (hmax <= lmin) begin
            r.flat = 1'b1;
        end else if (b.close >= hmax) begin
            r.percent_k = sok_pkg::K_FULL_SCALE;
        end else if (b.close > lmin) begin
            quot = (64'(b.close - lmin) * 64'(sok_pkg::K_FULL_SCALE)) / 64'(hmax - lmin);
            r.percent_k = quot[sok_pkg::K_W-1:0];
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [sok_pkg::PRICE_W-1:0] edge_price();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic apb_write(logic [sok_pkg::APB_AW-1:0] addr,
                             logic [sok_pkg::APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == LOOKBACK_ADDR) period_reg = data[sok_pkg::CFG_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(logic [sok_pkg::APB_AW-1:0] addr,
                            output logic [sok_pkg::APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_lookback();
        logic [sok_pkg::APB_DW-1:0] rd;
        apb_read(LOOKBACK_ADDR, rd);
        if (rd != sok_pkg::APB_DW'(period_reg))
            report_mismatch($sformatf("lookback_period reads %0d, expected %0d", rd, period_reg));
    endtask

    task automatic set_lookback(logic [sok_pkg::CFG_W-1:0] value);
        logic [sok_pkg::APB_DW-1:0] word;
        word = ($urandom & ~sok_pkg::APB_DW'({sok_pkg::CFG_W{1'b1}}))
             | sok_pkg::APB_DW'(value);
        apb_write(LOOKBACK_ADDR, word);
        check_lookback();
    endtask

    task automatic push_bar(logic [sok_pkg::PRICE_W-1:0] hi, logic [sok_pkg::PRICE_W-1:0] lo,
                            logic [sok_pkg::PRICE_W-1:0] cl, logic first);
        bar_t b;
        b = '{high: hi, low: lo, close: cl, first: first};
        bar_queue.push_back(b);
    endtask

    task automatic push_series(int unsigned n, series_kind_t kind, bit fresh);
        logic [sok_pkg::PRICE_W-1:0] mid, hi, lo, cl;
        int unsigned                 i;
        int                          step;
        mid = $urandom_range(32'h0100_0000, 32'hFEFF_FFFF);
        for (i = 0; i < n; i++) begin
            case (kind)
                SER_WALK: begin
                    step = int'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
                    mid  = mid + step;
                    hi   = mid + $urandom_range(0, 16'hFFFF);
                    lo   = mid - $urandom_range(0, 16'hFFFF);
                    case ($urandom_range(0, 9))
                        0: cl = lo - $urandom_range(0, 1000);
                        1: cl = hi + $urandom_range(0, 1000);
                        default: cl = lo + $urandom_range(0, hi - lo);
                    endcase
                end
                SER_FLAT: begin
                    hi = mid;
                    lo = mid;
                    cl = mid + $urandom_range(0, 2000) - 1000;
                end
                SER_EDGE: begin
                    hi = edge_price();
                    lo = edge_price();
                    cl = edge_price();
                end
                default: begin
                    hi = $urandom;
                    lo = $urandom;
                    cl = $urandom;
                end
            endcase
            push_bar(hi, lo, cl, (i == 0 && fresh) || $urandom_range(0, 39) == 0);
        end
    endtask

    task automatic wait_drained();
        while (bar_queue.size() != 0 || s_tvalid || k_expected.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // bar source
    always @(negedge aclk) begin : bar_driver
        bar_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (bar_queue.size() != 0) begin
                nxt = bar_queue.pop_front();
                s_tdata  <= {nxt.close, nxt.low, nxt.high};
                s_tuser  <= nxt.first;
                s_tvalid <= 1'b1;
                gap_left = tx_idle_on ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check first, then capture of the accepted bar
    always @(posedge aclk) begin : beat_monitor
        k_result_t               want;
        logic [sok_pkg::K_W-1:0] got_k;
        logic                    got_valid, got_flat;
        bar_t                    b;
        in_beat = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_k     = m_tdata[sok_pkg::K_W-1:0];
                got_valid = m_tuser[0];
                got_flat  = m_tuser[1];
                results_out++;
                if (k_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat k=%0d valid=%0b flat=%0b",
                                              got_k, got_valid, got_flat));
                end else begin
                    want = k_expected.pop_front();
                    if (got_k != want.percent_k)
                        report_mismatch($sformatf("result %0d: percent_k %0d, expected %0d",
                                                  results_out, got_k, want.percent_k));
                    if (got_valid != want.valid)
                        report_mismatch($sformatf("result %0d: result_valid %0b, expected %0b",
                                                  results_out, got_valid, want.valid));
                    if (got_flat != want.flat)
                        report_mismatch($sformatf("result %0d: flat_range %0b, expected %0b",
                                                  results_out, got_flat, want.flat));
                    if (want.valid) full_cnt++;
                    if (want.flat) flat_cnt++;
                    if (want.valid && !want.flat && want.percent_k == sok_pkg::K_FULL_SCALE)
                        top_cnt++;
                    if (want.valid && !want.flat && want.percent_k == 0) zero_cnt++;
                end
            end
            if (s_tvalid && s_tready) begin
                b = '{high: s_tdata[sok_pkg::PRICE_W-1:0],
                      low: s_tdata[2*sok_pkg::PRICE_W-1:sok_pkg::PRICE_W],
                      close: s_tdata[3*sok_pkg::PRICE_W-1:2*sok_pkg::PRICE_W],
                      first: s_tuser[0]};
                k_expected.push_back(predict_k(b));
                bars_in++;
                in_beat = 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Timeout: %0d bars accepted, %0d results pending", bars_in, k_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned       lookback_plan [NUM_PHASES];
        int unsigned       ph, span, target, pushed, len, r;
        series_kind_t      kind;
        bit                fresh;

        lookback_plan = '{14, 1, 64, 0, 127, 2, 3, 100, 5, 8, 20, 33, 63, 65, 1, 7, 0, 0};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_lookback();
        set_lookback(2);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        @(posedge aclk);
        push_bar(100, 50, 75, 1);                               // window still filling
        push_bar(200, 100, 150, 0);
        push_bar(0, 0, 0, 0);                                   // close on window low
        push_bar('1, 0, '1, 0);                                 // close on window high
        push_bar('1, '1, 0, 1);                                 // restart
        push_bar('1, '1, 5, 0);                                 // flat at top of range
        push_bar(10, 20, 15, 1);
        push_bar(10, 20, 15, 0);                                // inverted window
        push_bar(1000, 0, 999, 1);
        push_bar(1000, 0, 1, 0);
        push_bar(500, 100, 2000, 0);                            // close above high
        push_bar(300, 200, 50, 0);                              // close below low
        push_bar('1, 0, 32'h7FFF_FFFF, 1);
        push_bar(0, '1, 32'h8000_0000, 0);
        push_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h9999_9999, 0);
        push_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h6666_6666, 0);
        push_bar(0, 0, 0, 1);
        push_bar(1, 0, 1, 0);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph >= 16) lookback_plan[ph] = $urandom_range(0, 127);
            set_lookback(sok_pkg::CFG_W'(lookback_plan[ph]));
            if (ph == 5) begin
                apb_write(SPARE_ADDR, $urandom);
                check_lookback();
            end
            span       = window_len(sok_pkg::CFG_W'(lookback_plan[ph]));
            tx_idle_on = (ph != PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
            rx_idle_on = $urandom_range(0, 3) != 0;
            target     = 12 + span;
            pushed     = 0;
            fresh      = (ph == 0) || ($urandom_range(0, 9) < 7);
            @(posedge aclk);
            while (pushed < target) begin
                r = $urandom_range(0, 9);
                kind = (r == 0) ? SER_FLAT : (r == 1) ? SER_EDGE : (r == 2) ? SER_NOISE : SER_WALK;
                if ($urandom_range(0, 6) == 0) len = $urandom_range(1, span);
                else len = span + $urandom_range(0, 30);
                push_series(len, kind, fresh);
                pushed += len;
                fresh = 1'b1;
            end
            if (ph == PRESSURE_PHASE) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (PRESSURE_CYCLES) @(posedge aclk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (k_expected.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", k_expected.size()));
        $display("Ran %0d bars through %0d lookback settings (0, 1, 64 and oversize included).",
                 bars_in, NUM_PHASES + 1);
        $display("Results: %0d total, %0d full window, %0d flat, %0d at full scale, %0d at zero.",
                 results_out, full_cnt, flat_cnt, top_cnt, zero_cnt);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
